// ----- design/cosc_pkg.sv -----
// ----------------------------------------------------------------------------
// Collation order check package
// Shared widths, codes and the letter rank lookup of the sorted-list checker.
// ----------------------------------------------------------------------------
package cosc_pkg;

  // Longest word that is stored; later letters of a word are dropped.
  localparam int MAX_WORD_LEN = 32;
  localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
  localparam int IDX_W        = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

  localparam int LETTER_W = 5;
  localparam int RANK_W   = 5;
  localparam int CFG_W    = 60;
  localparam int YZ_W     = 10;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [CFG_W-1:0]    cfg_data_t;
  typedef logic [1:0]          cfg_index_t;

  // Register indexes of the configuration port.
  localparam cfg_index_t REG_RANK_A_L = 2'd0;
  localparam cfg_index_t REG_RANK_M_X = 2'd1;
  localparam cfg_index_t REG_RANK_Y_Z = 2'd2;

  // Decision state of the word pair being compared.
  typedef enum logic [1:0] {
    DEC_UNDECIDED = 2'd0,
    DEC_ORDERED   = 2'd1,
    DEC_UNORDERED = 2'd2
  } decision_t;

  localparam rank_t RANK_OUT_OF_RANGE = 5'd31;

  // Rank of a letter index from the three packed rank registers.
  function automatic rank_t rank_of(letter_t k, logic [CFG_W-1:0] a_to_l,
                                    logic [CFG_W-1:0] m_to_x,
                                    logic [YZ_W-1:0] y_z);
    letter_t k12;
    letter_t k24;
    rank_t   r;
    k12 = k - 5'd12;
    k24 = k - 5'd24;
    case (k) inside
      [5'd0:5'd11]:  r = a_to_l[k * 5 +: RANK_W];
      [5'd12:5'd23]: r = m_to_x[k12 * 5 +: RANK_W];
      [5'd24:5'd25]: r = y_z[k24[0] * 5 +: RANK_W];
      default:       r = RANK_OUT_OF_RANGE;
    endcase
    return r;
  endfunction

endpackage

// ----- design/cosc_channels.sv -----
// ----------------------------------------------------------------------------
// Collation order check channels
// Valid/ready interfaces for the letter stream and the verdict stream.
// ----------------------------------------------------------------------------
interface cosc_letter_if;
  import cosc_pkg::*;

  logic    valid;
  logic    ready;
  letter_t letter;
  logic    word_end;
  logic    list_end;

  modport source (output valid, output letter, output word_end, output list_end,
                  input ready);
  modport sink   (input valid, input letter, input word_end, input list_end,
                  output ready);
endinterface

interface cosc_verdict_if;
  logic valid;
  logic ready;
  logic in_order;
  logic word_too_long;

  modport source (output valid, output in_order, output word_too_long,
                  input ready);
  modport sink   (input valid, input in_order, input word_too_long,
                  output ready);
endinterface

// ----- design/collation_order_sorted_check.sv -----
// ----------------------------------------------------------------------------
// Collation order sorted check
// Decides whether a stream of words is sorted under a programmable letter order.
// ----------------------------------------------------------------------------
// Usage:
// The letters channel carries one letter per transaction, with flags that mark
// the last letter of a word and the last letter of the list. The verdict
// channel carries one transaction per list: in_order and word_too_long.
// Letter ranks come from three packed registers written over the cfg port. The
// user must write them only while the block is idle; the block itself does not
// enforce this. A write to an unused index is ignored. Each accepted letter
// lands in an input register, where it is compared with the stored letter at
// the same position of the previous word, using one rank lookup per side, and
// the list state is updated. A list-ending letter loads the verdict register.
// One letter is taken every cycle unless a list-ending letter waits for the
// verdict register; the rate is set by the single read of the 32-entry
// previous-word register file. When the receiver stalls, letters keep flowing
// until a list-ending letter finds the verdict register still full; that
// letter then waits in the input register and the letters channel stalls
// behind it. Reset empties both registers, clears the list state and restores
// the default ranks. The stored previous word needs no clearing.
// ----------------------------------------------------------------------------
module collation_order_sorted_check (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  cosc_pkg::cfg_index_t cfg_index,
  input  cosc_pkg::cfg_data_t  cfg_data,
  cosc_letter_if.sink          letters,
  cosc_verdict_if.source       verdict
);
  import cosc_pkg::*;

  // Rank registers.
  logic [CFG_W-1:0] rank_a_to_l;
  logic [CFG_W-1:0] rank_m_to_x;
  logic [YZ_W-1:0]  rank_y_z;

  // Input register.
  logic    s1_valid;
  letter_t s1_letter;
  logic    s1_word_end;
  logic    s1_list_end;

  // List state.
  letter_t   prev_letters [MAX_WORD_LEN];
  len_t      previous_length;
  len_t      position;
  decision_t decision;
  logic      have_previous;
  logic      all_ordered;
  logic      overflow_seen;

  // Verdict register.
  logic out_valid;
  logic out_in_order;
  logic out_too_long;

  // Datapath between the two registers.
  logic      out_free;
  logic      proc_fire;
  logic      in_range;
  letter_t   prev_letter;
  rank_t     prev_rank;
  rank_t     cur_rank;
  logic      cmp_en;
  decision_t decision_next;
  len_t      position_next;
  logic      overflow_next;
  logic      pair_ok;
  logic      all_ordered_next;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_a_to_l <= 60'd407901468851537952;
      rank_m_to_x <= 60'd854193664183220652;
      rank_y_z    <= 10'd824;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RANK_A_L: rank_a_to_l <= cfg_data;
        REG_RANK_M_X: rank_m_to_x <= cfg_data;
        REG_RANK_Y_Z: rank_y_z    <= cfg_data[YZ_W-1:0];
        default: ;
      endcase
    end
  end

  // A letter leaves the input register unless it ends a list and the verdict
  // register cannot take its result in this cycle.
  assign out_free      = !out_valid || verdict.ready;
  assign proc_fire     = s1_valid && (!s1_list_end || out_free);
  assign letters.ready = !s1_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (letters.valid && letters.ready) begin
      s1_valid <= 1'b1;
    end else if (proc_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (letters.valid && letters.ready) begin
      s1_letter   <= letters.letter;
      s1_word_end <= letters.word_end;
      s1_list_end <= letters.list_end;
    end
  end

  // Compare against the previous word at the same position. Only positions
  // below the previous length are read, and the previous word wrote them all.
  always_comb begin
    in_range    = position < len_t'(MAX_WORD_LEN);
    prev_letter = prev_letters[position[IDX_W-1:0]];
    prev_rank   = rank_of(prev_letter, rank_a_to_l, rank_m_to_x, rank_y_z);
    cur_rank    = rank_of(s1_letter, rank_a_to_l, rank_m_to_x, rank_y_z);
    cmp_en      = in_range && have_previous && (decision == DEC_UNDECIDED) &&
                  (position < previous_length);

    decision_next = decision;
    if (cmp_en) begin
      if (prev_rank < cur_rank) begin
        decision_next = DEC_ORDERED;
      end else if (prev_rank > cur_rank) begin
        decision_next = DEC_UNORDERED;
      end
    end

    position_next = in_range ? position + len_t'(1) : position;
    overflow_next = overflow_seen || !in_range;

    // With all shared letters equal, the pair is in order when the current
    // word is at least as long as the previous one.
    if (decision_next == DEC_UNDECIDED) begin
      pair_ok = previous_length <= position_next;
    end else begin
      pair_ok = decision_next == DEC_ORDERED;
    end
    all_ordered_next = all_ordered && (!have_previous || pair_ok);
  end

  // The current word overwrites the previous one letter by letter; the read
  // above sees the old entry in the same cycle.
  always_ff @(posedge clk) begin
    if (proc_fire && in_range) begin
      prev_letters[position[IDX_W-1:0]] <= s1_letter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_length <= '0;
      position        <= '0;
      decision        <= DEC_UNDECIDED;
      have_previous   <= 1'b0;
      all_ordered     <= 1'b1;
      overflow_seen   <= 1'b0;
    end else if (proc_fire) begin
      if (s1_list_end) begin
        // The list is done: start the next one from scratch.
        previous_length <= '0;
        position        <= '0;
        decision        <= DEC_UNDECIDED;
        have_previous   <= 1'b0;
        all_ordered     <= 1'b1;
        overflow_seen   <= 1'b0;
      end else if (s1_word_end) begin
        previous_length <= position_next;
        position        <= '0;
        decision        <= DEC_UNDECIDED;
        have_previous   <= 1'b1;
        all_ordered     <= all_ordered_next;
        overflow_seen   <= overflow_next;
      end else begin
        position        <= position_next;
        decision        <= decision_next;
        overflow_seen   <= overflow_next;
      end
    end
  end

  // Verdict register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && s1_list_end) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && s1_list_end) begin
      out_in_order <= all_ordered_next;
      out_too_long <= overflow_next;
    end
  end

  assign verdict.valid         = out_valid;
  assign verdict.in_order      = out_in_order;
  assign verdict.word_too_long = out_too_long;

`ifndef NO_ASSERTIONS
  // A new verdict appears only after a list-ending letter was processed.
  a_verdict_from_list_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(proc_fire && s1_list_end))
    else $error("verdict raised without a list-ending letter");

  // A list-ending letter is never processed over an untaken verdict.
  a_no_verdict_overwrite: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && s1_list_end) |-> (!out_valid || verdict.ready))
    else $error("verdict register overwritten while stalled");

  // Without a previous word no pair can have been decided.
  a_no_decision_first_word: assert property (@(posedge clk) disable iff (rst)
    !have_previous |-> (decision == DEC_UNDECIDED))
    else $error("pair decided with no previous word");

  // Position and stored length saturate at the word limit.
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    (position <= len_t'(MAX_WORD_LEN)) && (previous_length <= len_t'(MAX_WORD_LEN)))
    else $error("word position beyond the stored length limit");
`endif

endmodule

// ----- tb/sv/collation_order_sorted_check_tb.sv -----
// ----------------------------------------------------------------------------
// Collation order sorted check testbench
// Streams word lists into the checker under several letter orders. Each list
// verdict is compared with a cycle-free predictor of the list state or with a
// verdict typed into the table at the start. The table covers the corner
// cases; random lists of related words follow. Both channels idle at random.
// ----------------------------------------------------------------------------
module collation_order_sorted_check_tb;
  import cosc_pkg::*;

  // Index with no register behind it; writes to it must leave the ranks alone.
  localparam cfg_index_t REG_UNUSED = 2'd3;

  localparam int PHASE_ITEMS    = 85;
  localparam int STALL_LIMIT    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 10;

  typedef struct packed {
    logic in_order;
    logic word_too_long;
  } verdict_t;

  // One row of the directed table. The letter is repeated reps times and the
  // flags apply to the last copy only. When typed is set, the row ends a list
  // whose verdict is given in the row instead of by the predictor.
  typedef struct packed {
    letter_t    letter;
    logic [5:0] reps;
    logic       word_end;
    logic       list_end;
    logic       typed;
    logic       in_order;
    logic       too_long;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // A single one-letter word, lowest letter index: sorted by definition.
    '{5'd0,  6'd1,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    // Two equal words that start with an out-of-range letter; the list end
    // carries no word end flag.
    '{5'd31, 6'd1,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd25, 6'd1,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd31, 6'd1,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd25, 6'd1,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
    // A word followed by its own strict prefix is out of order.
    '{5'd5,  6'd1,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd6,  6'd1,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd5,  6'd1,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    // A word followed by an extension of itself is in order.
    '{5'd7,  6'd1,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd7,  6'd1,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd8,  6'd1,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    // Decided by the default ranks of the first letters.
    '{5'd3,  6'd1,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd20, 6'd1,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd4,  6'd1,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd9,  6'd1,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    // Two different out-of-range letters share a rank and compare equal.
    '{5'd26, 6'd1,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd30, 6'd1,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    // One word longer than the store: truncated and flagged.
    '{5'd2,  6'd33, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
    // The overflow flag belongs to the list and is cleared with it.
    '{5'd1,  6'd1,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    // Letters from all three rank registers, decided by rank.
    '{5'd24, 6'd1,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd12, 6'd1,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd11, 6'd1,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  cosc_letter_if  letters_ch ();
  cosc_verdict_if verdict_ch ();

  collation_order_sorted_check dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .letters   (letters_ch),
    .verdict   (verdict_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Verdicts the predictor has worked out and the block has not yet sent.
  verdict_t verdicts_due[$];
  int       mismatches;

  // When set, neither side idles; the sender sets it per list so that
  // back-to-back stretches appear between the idle ones.
  bit       no_idle;

  // ---------------------------------------------------------------------------
  // Predictor: its own copy of the rank registers and of the list state.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] rk_a_l;
  logic [CFG_W-1:0] rk_m_x;
  logic [YZ_W-1:0]  rk_y_z;

  letter_t   prior_letters [MAX_WORD_LEN];
  len_t      prior_len;
  len_t      cur_pos;
  decision_t pair_state;
  logic      seen_word;
  logic      list_sorted;
  logic      list_overflow;

  function automatic rank_t lookup_rank(letter_t k);
    int unsigned i;
    i = k;
    if (i < 12) return rank_t'(rk_a_l >> (RANK_W * i));
    if (i < 24) return rank_t'(rk_m_x >> (RANK_W * (i - 12)));
    if (i < 26) return rank_t'(rk_y_z >> (RANK_W * (i - 24)));
    return RANK_OUT_OF_RANGE;
  endfunction

  task automatic clear_list_state();
    prior_len     = '0;
    cur_pos       = '0;
    pair_state    = DEC_UNDECIDED;
    seen_word     = 1'b0;
    list_sorted   = 1'b1;
    list_overflow = 1'b0;
  endtask

  // Advances the list state by one letter; a list end yields a verdict.
  task automatic collate_letter(input letter_t l, input logic we, input logic le,
                                output bit got, output verdict_t v);
    rank_t held;
    rank_t now;
    logic  pair_ok;
    got = 1'b0;
    v   = '0;
    if (cur_pos < MAX_WORD_LEN) begin
      if (seen_word && pair_state == DEC_UNDECIDED && cur_pos < prior_len) begin
        held = lookup_rank(prior_letters[cur_pos[IDX_W-1:0]]);
        now  = lookup_rank(l);
        if (held < now) pair_state = DEC_ORDERED;
        else if (held > now) pair_state = DEC_UNORDERED;
      end
      prior_letters[cur_pos[IDX_W-1:0]] = l;
      cur_pos = cur_pos + 1'b1;
    end else begin
      list_overflow = 1'b1;
    end
    // A list end closes the current word even without its own flag.
    if (we || le) begin
      if (seen_word) begin
        if (pair_state == DEC_UNDECIDED) pair_ok = (prior_len <= cur_pos);
        else pair_ok = (pair_state == DEC_ORDERED);
        if (!pair_ok) list_sorted = 1'b0;
      end
      prior_len  = cur_pos;
      seen_word  = 1'b1;
      pair_state = DEC_UNDECIDED;
      cur_pos    = '0;
    end
    if (le) begin
      v.in_order      = list_sorted;
      v.word_too_long = list_overflow;
      got             = 1'b1;
      clear_list_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking and watchdog.
  // ---------------------------------------------------------------------------
  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Every verdict transaction is matched against the oldest pending one.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && verdict_ch.valid && verdict_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        report("verdict transaction with no list pending");
      end else begin
        want = verdicts_due.pop_front();
        if (verdict_ch.in_order !== want.in_order)
          report($sformatf("in_order got %b want %b", verdict_ch.in_order,
                           want.in_order));
        if (verdict_ch.word_too_long !== want.word_too_long)
          report($sformatf("word_too_long got %b want %b",
                           verdict_ch.word_too_long, want.word_too_long));
      end
    end
  end

  // Stuck run: the idle count, cleared on any channel move, reaches STALL_LIMIT.
  int stall_cycles;
  always @(posedge clk) begin
    if (rst || (letters_ch.valid && letters_ch.ready) ||
        (verdict_ch.valid && verdict_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d verdicts pending", stall_cycles,
               verdicts_due.size());
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: after each verdict transaction it draws whether and how long to
  // hold ready low; with no_idle set it keeps ready high.
  int ready_hold;
  int ready_draw;
  always @(posedge clk) begin
    if (rst) begin
      verdict_ch.ready <= 1'b0;
      ready_hold       <= 0;
    end else if (verdict_ch.ready) begin
      if (verdict_ch.valid) begin
        ready_draw = no_idle ? 0 : $urandom_range(0, 6);
        if (ready_draw != 0) begin
          verdict_ch.ready <= 1'b0;
          ready_hold       <= ready_draw;
        end
      end
    end else if (ready_hold <= 1) begin
      verdict_ch.ready <= 1'b1;
      ready_hold       <= 0;
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offers one letter after a drawn gap and waits for its transaction. A
  // typed verdict, where given, stands in for the predicted one.
  task automatic send_letter(input letter_t l, input logic we, input logic le,
                             input bit typed, input verdict_t typed_v);
    int       gap;
    bit       got;
    verdict_t v;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      letters_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    letters_ch.valid    <= 1'b1;
    letters_ch.letter   <= l;
    letters_ch.word_end <= we;
    letters_ch.list_end <= le;
    @(posedge clk);
    while (!letters_ch.ready) @(posedge clk);
    collate_letter(l, we, le, got, v);
    if (got) verdicts_due.push_back(typed ? typed_v : v);
  endtask

  // Stops the letter stream and waits for every pending verdict, then lets
  // the block settle.
  task automatic drain();
    letters_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic cfg_data_t rand60();
    return cfg_data_t'({$urandom, $urandom});
  endfunction

  task automatic cfg_put(input cfg_index_t idx, input cfg_data_t data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_RANK_A_L: rk_a_l = data;
      REG_RANK_M_X: rk_m_x = data;
      REG_RANK_Y_Z: rk_y_z = data[YZ_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all three rank registers back to back, then the unused index when
  // asked; the write enable drops once, after the last write.
  task automatic load_ranks(input cfg_data_t a_l, input cfg_data_t m_x,
                            input cfg_data_t y_z, input bit poke_unused);
    cfg_put(REG_RANK_A_L, a_l);
    cfg_put(REG_RANK_M_X, m_x);
    cfg_put(REG_RANK_Y_Z, y_z);
    if (poke_unused) cfg_put(REG_UNUSED, rand60());
    cfg_write <= 1'b0;
  endtask

  // Rank k = k, or 25 - k when descending. The bits above the y/z field carry
  // junk that the block must mask off.
  task automatic load_linear_order(input bit descending, input bit poke_unused);
    cfg_data_t a_l;
    cfg_data_t m_x;
    cfg_data_t y_z;
    a_l = '0;
    m_x = '0;
    for (int k = 0; k < 12; k++) begin
      a_l[k*RANK_W +: RANK_W] = rank_t'(descending ? 25 - k : k);
      m_x[k*RANK_W +: RANK_W] = rank_t'(descending ? 13 - k : k + 12);
    end
    y_z = rand60() << YZ_W;
    y_z[YZ_W-1:0] = descending ? {5'd0, 5'd1} : {5'd25, 5'd24};
    load_ranks(a_l, m_x, y_z, poke_unused);
  endtask

  // ---------------------------------------------------------------------------
  // Random lists. Most words are derived from the word before them, so that
  // pairs are equal, extended, cut to a prefix or decided at some position;
  // the rest are random words and whole random lists.
  // ---------------------------------------------------------------------------
  letter_t prior_word[$];
  letter_t cur_word[$];
  int      list_count;

  function automatic letter_t rand_letter();
    if ($urandom_range(0, 9) == 0) return letter_t'($urandom_range(26, 31));
    return letter_t'($urandom_range(0, 25));
  endfunction

  // A letter ranked strictly above r when a few draws find one.
  function automatic letter_t pick_above(rank_t r);
    letter_t c;
    for (int t = 0; t < 8; t++) begin
      c = rand_letter();
      if (lookup_rank(c) > r) return c;
    end
    return rand_letter();
  endfunction

  task automatic random_word();
    int len;
    len = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40)
                                       : $urandom_range(1, 6);
    cur_word.delete();
    repeat (len) cur_word.push_back(rand_letter());
  endtask

  task automatic derived_word();
    int pick;
    int p;
    pick = $urandom_range(0, 99);
    cur_word.delete();
    if (pick < 20) begin
      cur_word = prior_word;
    end else if (pick < 40) begin
      cur_word = prior_word;
      repeat ($urandom_range(1, 3)) cur_word.push_back(rand_letter());
    end else if (pick < 75) begin
      // Shared prefix, then a letter picked to rank higher decides the pair.
      p = $urandom_range(0, prior_word.size() - 1);
      for (int i = 0; i < p; i++) cur_word.push_back(prior_word[i]);
      cur_word.push_back(pick_above(lookup_rank(prior_word[p])));
      repeat ($urandom_range(0, 3)) cur_word.push_back(rand_letter());
    end else if (pick < 85 && prior_word.size() > 1) begin
      p = $urandom_range(1, prior_word.size() - 1);
      for (int i = 0; i < p; i++) cur_word.push_back(prior_word[i]);
    end else begin
      random_word();
    end
  endtask

  task automatic run_lists(input int n_items);
    int sent;
    int words;
    bit noise;
    bit last_word;
    bit last_letter;
    sent = 0;
    while (sent < n_items) begin
      list_count++;
      // Now and then hold the stream until the block has answered everything.
      if (list_count % 6 == 0) drain();
      no_idle = ($urandom_range(0, 3) == 0);
      noise   = ($urandom_range(0, 5) == 0);
      words   = $urandom_range(1, 5);
      prior_word.delete();
      for (int w = 0; w < words; w++) begin
        if (w == 0 || noise) random_word();
        else derived_word();
        last_word = (w == words - 1);
        foreach (cur_word[i]) begin
          last_letter = (i == cur_word.size() - 1);
          send_letter(cur_word[i],
                      last_letter && (!last_word || $urandom_range(0, 1)),
                      last_letter && last_word, 1'b0, '0);
        end
        sent += cur_word.size();
        prior_word = cur_word;
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, the directed table under the default ranks, then
  // random lists under each rank setting.
  // ---------------------------------------------------------------------------
  initial begin
    verdict_t typed_v;
    bit       last;
    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = REG_RANK_A_L;
    cfg_data            = '0;
    letters_ch.valid    = 1'b0;
    letters_ch.letter   = '0;
    letters_ch.word_end = 1'b0;
    letters_ch.list_end = 1'b0;
    mismatches          = 0;
    list_count          = 0;
    no_idle             = 1'b0;

    rk_a_l = 60'd407901468851537952;
    rk_m_x = 60'd854193664183220652;
    rk_y_z = 10'd824;
    foreach (prior_letters[i]) prior_letters[i] = '0;
    clear_list_state();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      typed_v.in_order      = DIRECTED[r].in_order;
      typed_v.word_too_long = DIRECTED[r].too_long;
      for (int n = 0; n < DIRECTED[r].reps; n++) begin
        last = (n == DIRECTED[r].reps - 1);
        send_letter(DIRECTED[r].letter, last && DIRECTED[r].word_end,
                    last && DIRECTED[r].list_end, DIRECTED[r].typed, typed_v);
      end
    end
    run_lists(PHASE_ITEMS);

    // All ranks equal: only lengths and out-of-range letters decide.
    drain();
    load_ranks('0, '0, '0, 1'b0);
    run_lists(PHASE_ITEMS);

    // All ranks at the top, the same rank as an out-of-range letter.
    drain();
    load_ranks('1, '1, '1, 1'b0);
    run_lists(PHASE_ITEMS);

    drain();
    load_linear_order(1'b0, 1'b1);
    run_lists(PHASE_ITEMS);

    drain();
    load_linear_order(1'b1, 1'b0);
    run_lists(PHASE_ITEMS);

    repeat (2) begin
      drain();
      load_ranks(rand60(), rand60(), rand60(), $urandom_range(0, 1));
      run_lists(PHASE_ITEMS);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
